[rtl/brightness_link_controller_unit_assert.svh]
// ----------------------------------------------------------------------------
// brightness link controller assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BRIGHTNESS_LINK_CONTROLLER_UNIT_ASSERT_SVH
`define BRIGHTNESS_LINK_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define BLC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brightness link controller check failed");

// next-cycle implication
`define BLC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brightness link controller check failed");

`endif

[rtl/blc_pkg.sv]
// ----------------------------------------------------------------------------
// blc_pkg
// types, codes and helpers shared by the brightness link controller
// ----------------------------------------------------------------------------
package blc_pkg;

  localparam int unsigned AddrW = 4;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
  localparam logic [1:0] REG_MIN_LEVEL     = 2'd1;
  localparam logic [1:0] REG_MAX_LEVEL     = 2'd2;
  localparam logic [1:0] REG_DEFAULT_LEVEL = 2'd3;

  localparam logic [7:0] RETRY_LIMIT_RST   = 8'd10;
  localparam logic [3:0] MIN_LEVEL_RST     = 4'd3;
  localparam logic [3:0] MAX_LEVEL_RST     = 4'd10;
  localparam logic [3:0] DEFAULT_LEVEL_RST = 4'd9;

  // item commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DONE  = 1'b1;

  // request codes
  localparam logic [1:0] REQ_INC     = 2'd0;
  localparam logic [1:0] REQ_DEC     = 2'd1;
  localparam logic [1:0] REQ_SET     = 2'd2;
  localparam logic [1:0] REQ_DEFAULT = 2'd3;

  // result status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_SUCCESS    = 3'd1;
  localparam logic [2:0] ST_READ_FAIL  = 3'd2;
  localparam logic [2:0] ST_WRITE_FAIL = 3'd3;
  localparam logic [2:0] ST_IGNORED    = 3'd4;

  localparam logic [7:0] POLL_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [3:0] min_level;
    logic [3:0] max_level;
    logic [3:0] default_level;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [1:0]        request;
    logic signed [7:0] level_value;
    logic [7:0]        rx_byte;
    logic              xfer_ok;
  } item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [2:0] status;
    logic [3:0] read_level;
    logic [3:0] new_level;
    logic       lid_closed;
    logic       screen_off;
    logic       shutdown_req;
  } result_t;

  // parity of the low seven bits
  function automatic logic par7(input logic [7:0] v);
    par7 = ^v[6:0];
  endfunction

endpackage

[rtl/blc_cfg.sv]
// ----------------------------------------------------------------------------
// blc_cfg
// apb register file holding retry limit, level clamp and default level
// ----------------------------------------------------------------------------
module blc_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [blc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output blc_pkg::cfg_t            cfg
);

  blc_pkg::cfg_t cfg_r;
  blc_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        blc_pkg::REG_RETRY_LIMIT:   cfg_nxt.retry_limit   = pwdata[7:0];
        blc_pkg::REG_MIN_LEVEL:     cfg_nxt.min_level     = pwdata[3:0];
        blc_pkg::REG_MAX_LEVEL:     cfg_nxt.max_level     = pwdata[3:0];
        blc_pkg::REG_DEFAULT_LEVEL: cfg_nxt.default_level = pwdata[3:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit   <= blc_pkg::RETRY_LIMIT_RST;
      cfg_r.min_level     <= blc_pkg::MIN_LEVEL_RST;
      cfg_r.max_level     <= blc_pkg::MAX_LEVEL_RST;
      cfg_r.default_level <= blc_pkg::DEFAULT_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      blc_pkg::REG_RETRY_LIMIT:   prdata = {24'd0, cfg_r.retry_limit};
      blc_pkg::REG_MIN_LEVEL:     prdata = {28'd0, cfg_r.min_level};
      blc_pkg::REG_MAX_LEVEL:     prdata = {28'd0, cfg_r.max_level};
      blc_pkg::REG_DEFAULT_LEVEL: prdata = {28'd0, cfg_r.default_level};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/blc_core.sv]
// ----------------------------------------------------------------------------
// blc_core
// link sequencer: status check, level forming, echo check and retry count
// ----------------------------------------------------------------------------
`include "brightness_link_controller_unit_assert.svh"

module blc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  blc_pkg::cfg_t    cfg,
  input  logic             fire,
  input  blc_pkg::item_t   item,
  output blc_pkg::result_t res
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  logic [1:0] phase_r,      phase_nxt;
  logic [7:0] retry_r,      retry_nxt;
  logic [1:0] pend_req_r,   pend_req_nxt;
  logic [7:0] pend_val_r,   pend_val_nxt;
  logic [7:0] cmd_byte_r,   cmd_byte_nxt;
  logic [6:0] stat_flds_r,  stat_flds_nxt;

  logic              read_good;
  logic              write_good;
  logic              can_retry;
  logic [3:0]        cur_level;
  logic signed [8:0] lv_raw;
  logic signed [8:0] lv_hi;
  logic signed [8:0] lv_clip;
  logic [3:0]        lvl;
  logic [7:0]        formed_byte;
  logic              send_v;
  logic [7:0]        send_b;
  logic [2:0]        st;

  assign read_good  = item.xfer_ok && (blc_pkg::par7(item.rx_byte) == item.rx_byte[7]);
  assign write_good = item.xfer_ok && (item.rx_byte[6:3] == cmd_byte_r[6:3]);
  assign can_retry  = retry_r < cfg.retry_limit;
  assign cur_level  = item.rx_byte[6:3];

  // new level from the fresh status byte and the stored request
  always_comb begin
    case (pend_req_r)
      blc_pkg::REQ_INC: lv_raw = $signed({5'd0, cur_level}) + 9'sd1;
      blc_pkg::REQ_DEC: lv_raw = $signed({5'd0, cur_level}) - 9'sd1;
      blc_pkg::REQ_SET: lv_raw = $signed({pend_val_r[7], pend_val_r});
      default:          lv_raw = $signed({5'd0, cfg.default_level});
    endcase
  end

  // clamp to max first, then raise to min
  assign lv_hi   = (lv_raw > $signed({5'd0, cfg.max_level})) ?
                   $signed({5'd0, cfg.max_level}) : lv_raw;
  assign lv_clip = (lv_hi < $signed({5'd0, cfg.min_level})) ?
                   $signed({5'd0, cfg.min_level}) : lv_hi;
  assign lvl     = lv_clip[3:0];
  // bit 7 carries parity of bits 0-6; bits 0-2 are zero
  assign formed_byte = {^lvl, lvl, 3'b000};

  always_comb begin
    phase_nxt     = phase_r;
    retry_nxt     = retry_r;
    pend_req_nxt  = pend_req_r;
    pend_val_nxt  = pend_val_r;
    cmd_byte_nxt  = cmd_byte_r;
    stat_flds_nxt = stat_flds_r;
    send_v        = 1'b0;
    send_b        = 8'd0;
    st            = blc_pkg::ST_IGNORED;
    if (item.command == blc_pkg::CMD_START) begin
      if (phase_r == PH_IDLE) begin
        pend_req_nxt = item.request;
        pend_val_nxt = item.level_value;
        retry_nxt    = 8'd0;
        phase_nxt    = PH_READ;
        send_v       = 1'b1;
        send_b       = blc_pkg::POLL_BYTE;
        st           = blc_pkg::ST_BUSY;
      end
    end else begin
      case (phase_r)
        PH_READ: begin
          if (read_good) begin
            stat_flds_nxt = item.rx_byte[6:0];
            cmd_byte_nxt  = formed_byte;
            retry_nxt     = 8'd0;
            phase_nxt     = PH_WRITE;
            send_v        = 1'b1;
            send_b        = formed_byte;
            st            = blc_pkg::ST_BUSY;
          end else if (can_retry) begin
            retry_nxt = retry_r + 8'd1;
            send_v    = 1'b1;
            send_b    = blc_pkg::POLL_BYTE;
            st        = blc_pkg::ST_BUSY;
          end else begin
            phase_nxt = PH_IDLE;
            st        = blc_pkg::ST_READ_FAIL;
          end
        end
        PH_WRITE: begin
          if (write_good) begin
            phase_nxt = PH_IDLE;
            st        = blc_pkg::ST_SUCCESS;
          end else if (can_retry) begin
            retry_nxt = retry_r + 8'd1;
            send_v    = 1'b1;
            send_b    = cmd_byte_r;
            st        = blc_pkg::ST_BUSY;
          end else begin
            phase_nxt = PH_IDLE;
            st        = blc_pkg::ST_WRITE_FAIL;
          end
        end
        default: begin
          st = blc_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      retry_r     <= 8'd0;
      pend_req_r  <= 2'd0;
      pend_val_r  <= 8'd0;
      cmd_byte_r  <= 8'd0;
      stat_flds_r <= 7'd0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      retry_r     <= retry_nxt;
      pend_req_r  <= pend_req_nxt;
      pend_val_r  <= pend_val_nxt;
      cmd_byte_r  <= cmd_byte_nxt;
      stat_flds_r <= stat_flds_nxt;
    end
  end

  // result reflects the state after this beat
  always_comb begin
    res.send_valid   = send_v;
    res.send_byte    = send_b;
    res.status       = st;
    res.read_level   = stat_flds_nxt[6:3];
    res.new_level    = cmd_byte_nxt[6:3];
    res.lid_closed   = stat_flds_nxt[2];
    res.screen_off   = stat_flds_nxt[1];
    res.shutdown_req = stat_flds_nxt[0];
  end

  `BLC_ASSERT_NXT(a_start_enters_read,
    fire && item.command == blc_pkg::CMD_START && phase_r == PH_IDLE,
    phase_r == PH_READ && retry_r == 8'd0)
  `BLC_ASSERT_IMP(a_success_only_in_write,
    fire && res.status == blc_pkg::ST_SUCCESS, phase_r == PH_WRITE)
  `BLC_ASSERT_NXT(a_fail_returns_idle,
    fire && (res.status == blc_pkg::ST_READ_FAIL || res.status == blc_pkg::ST_WRITE_FAIL),
    phase_r == PH_IDLE)
  `BLC_ASSERT_IMP(a_write_resend_same_byte,
    fire && res.send_valid && phase_r == PH_WRITE && item.command == blc_pkg::CMD_DONE,
    res.send_byte == cmd_byte_r)

endmodule

[rtl/brightness_link_controller_unit.sv]
// ----------------------------------------------------------------------------
// brightness_link_controller_unit
// host-side sequencer for a one-byte spi link to a display hub
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. A start beat (command 0)
// asks for a 0xFF status poll; a transfer-done beat (command 1) hands in the
// byte the hub returned. A good status (xfer_ok set, bit 7 equal to the parity
// of bits 0-6) is decoded into lid, screen-off, shutdown and a four-bit level,
// and a new level is formed from the stored request, clamped to max_level and
// then raised to min_level, and sent as a command byte until the hub echoes
// the level bits. Failed checks are retried up to retry_limit extra times.
// Throughput is one beat per clock while out_stall is low: a beat sits in the
// input register while the sequencer logic works on it, and its result lands
// in the output register, which drives out_valid.
// Settings are written over the apb port (pready always high); the user must
// write them only while no request is in flight (not enforced by the block).
module brightness_link_controller_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // apb configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [blc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [1:0]                in_request,
  input  logic signed [7:0]         in_level_value,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_xfer_ok,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_send_valid,
  output logic [7:0]                out_send_byte,
  output logic [2:0]                out_status,
  output logic [3:0]                out_read_level,
  output logic [3:0]                out_new_level,
  output logic                      out_lid_closed,
  output logic                      out_screen_off,
  output logic                      out_shutdown_req
);

  blc_pkg::cfg_t    cfg;
  blc_pkg::item_t   item_r;
  blc_pkg::result_t res;
  blc_pkg::result_t res_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             out_free;
  logic             fire;

  blc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // the held beat is processed when its result has somewhere to go
  assign fire     = in_valid_r && out_free;
  // input register only blocks when its beat cannot move on
  assign in_stall = in_valid_r && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.command     <= in_command;
      item_r.request     <= in_request;
      item_r.level_value <= in_level_value;
      item_r.rx_byte     <= in_rx_byte;
      item_r.xfer_ok     <= in_xfer_ok;
    end
  end

  blc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_valid   = res_r.send_valid;
  assign out_send_byte    = res_r.send_byte;
  assign out_status       = res_r.status;
  assign out_read_level   = res_r.read_level;
  assign out_new_level    = res_r.new_level;
  assign out_lid_closed   = res_r.lid_closed;
  assign out_screen_off   = res_r.screen_off;
  assign out_shutdown_req = res_r.shutdown_req;

endmodule
